>>> hdl/ppm_ebp_pkg.sv
// Shared types and constants for the per-channel peak program meter.
// Holds the item structs and the fixed widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppm_ebp_pkg;

	// Number of channels with their own envelope and block peak.
	localparam int CHANNELS = 8;
	localparam int CH_IDX_W = $clog2(CHANNELS);

	localparam int SMP_W   = 16;
	localparam int CH_W    = 3;
	localparam int ENV_W   = 24;   // 16.8 envelope
	localparam int ALPHA_W = 24;   // Q0.24 coefficient
	localparam int OUT_W   = 16;

	// Configuration register indexes.
	localparam logic REG_ALPHA_ATTACK  = 1'b0;
	localparam logic REG_ALPHA_RELEASE = 1'b1;

	localparam logic [ALPHA_W-1:0] ALPHA_ATTACK_RST  = 24'd76722;
	localparam logic [ALPHA_W-1:0] ALPHA_RELEASE_RST = 24'd513;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic [CH_W-1:0]         channel;
		logic                    block_start;
	} smp_t;

	typedef struct packed {
		logic [CH_W-1:0]  out_channel;
		logic [OUT_W-1:0] envelope;
		logic [OUT_W-1:0] block_peak;
	} res_t;

endpackage

`default_nettype wire

>>> hdl/ppm_ebp_upd.sv
// Envelope update datapath: one attack or release step of a 16.8 envelope.
// Depends on ppm_ebp_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module ppm_ebp_upd (
	input  wire logic [ppm_ebp_pkg::ENV_W-1:0]   env,
	input  wire logic [ppm_ebp_pkg::OUT_W-1:0]   mag,
	input  wire logic [ppm_ebp_pkg::ALPHA_W-1:0] alpha_attack,
	input  wire logic [ppm_ebp_pkg::ALPHA_W-1:0] alpha_release,
	output logic      [ppm_ebp_pkg::ENV_W-1:0]   env_next
);

	logic [ppm_ebp_pkg::ENV_W-1:0]                         mag8;
	logic                                                  attack;
	logic [ppm_ebp_pkg::ENV_W-1:0]                         opnd;
	logic [ppm_ebp_pkg::ALPHA_W-1:0]                       coef;
	logic [ppm_ebp_pkg::ALPHA_W+ppm_ebp_pkg::ENV_W-1:0]    prod;
	logic [ppm_ebp_pkg::ENV_W-1:0]                         prod_hi;
	logic                                                  frac_nz;

	// The attack blend a*m + (1-a)*e equals e + a*(m-e), and the release
	// product e*(1-a) equals e - ceil(e*a), so one multiplier serves both.
	assign mag8    = {mag, 8'd0};
	assign attack  = (env <= mag8);
	assign opnd    = attack ? (mag8 - env) : env;
	assign coef    = attack ? alpha_attack : alpha_release;
	assign prod    = {{ppm_ebp_pkg::ENV_W{1'b0}}, coef} * {{ppm_ebp_pkg::ALPHA_W{1'b0}}, opnd};
	assign prod_hi = prod[ppm_ebp_pkg::ALPHA_W+ppm_ebp_pkg::ENV_W-1:ppm_ebp_pkg::ALPHA_W];
	assign frac_nz = |prod[ppm_ebp_pkg::ALPHA_W-1:0];

	assign env_next = attack ? (env + prod_hi)
	                         : (env - prod_hi - {{(ppm_ebp_pkg::ENV_W-1){1'b0}}, frac_nz});

endmodule

`default_nettype wire

>>> hdl/ppm_envelope_block_peak_core.sv
// Per-channel peak program meter, top level. An accepted item passes through
// the input register, then the result register, where res_valid shows it.
// Throughput: one item per cycle while res_stall does not hold the output, set
// by the single read-modify-write of the per-channel envelope and peak
// registers, which holds even on one channel.
// Reset: arst_n clears both pipeline valids, all envelopes and block peaks,
// and loads the default attack and release coefficients.
`timescale 1ns / 1ps
`default_nettype none

module ppm_envelope_block_peak_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Sample channel.
	input  wire logic               smp_valid,
	output logic                    smp_stall,
	input  wire ppm_ebp_pkg::smp_t  smp,
	// Result channel.
	output logic                    res_valid,
	input  wire logic               res_stall,
	output ppm_ebp_pkg::res_t       res,
	// Configuration port.
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	// Coefficient registers.
	logic [ppm_ebp_pkg::ALPHA_W-1:0] alpha_attack_q;
	logic [ppm_ebp_pkg::ALPHA_W-1:0] alpha_release_q;

	// Per-channel state: envelope and block peak, both 16.8.
	logic [ppm_ebp_pkg::ENV_W-1:0] env_q  [ppm_ebp_pkg::CHANNELS];
	logic [ppm_ebp_pkg::ENV_W-1:0] peak_q [ppm_ebp_pkg::CHANNELS];

	// Stage 1 holds the accepted item; stage 2 is the result register.
	ppm_ebp_pkg::smp_t smp_s1;
	logic              vld_s1;
	ppm_ebp_pkg::res_t res_s2;
	logic              vld_s2;

	logic                                   load_s2;
	logic [ppm_ebp_pkg::CH_IDX_W-1:0]       idx;
	logic                                   in_range;
	logic [ppm_ebp_pkg::OUT_W-1:0]          sample_u;
	logic [ppm_ebp_pkg::OUT_W-1:0]          mag;
	logic [ppm_ebp_pkg::ENV_W-1:0]          env_cur;
	logic [ppm_ebp_pkg::ENV_W-1:0]          env_next;
	logic [ppm_ebp_pkg::ENV_W-1:0]          peak_base;
	logic [ppm_ebp_pkg::ENV_W-1:0]          peak_next;
	logic                                   commit;
	logic                                   cfg_wr;

	// The APB port never waits. Registers decode on address bit 2 alone.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			ppm_ebp_pkg::REG_ALPHA_ATTACK:  prdata = {8'd0, alpha_attack_q};
			ppm_ebp_pkg::REG_ALPHA_RELEASE: prdata = {8'd0, alpha_release_q};
			default:                        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_attack_q  <= ppm_ebp_pkg::ALPHA_ATTACK_RST;
			alpha_release_q <= ppm_ebp_pkg::ALPHA_RELEASE_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == ppm_ebp_pkg::REG_ALPHA_RELEASE) begin
				alpha_release_q <= pwdata[ppm_ebp_pkg::ALPHA_W-1:0];
			end else begin
				alpha_attack_q <= pwdata[ppm_ebp_pkg::ALPHA_W-1:0];
			end
		end
	end

	// The result register loads whenever it is empty or being taken, and
	// stage 1 moves with it. An item is therefore held back only while a
	// finished result waits and a second item already sits in stage 1.
	assign load_s2   = !vld_s2 || !res_stall;
	assign smp_stall = vld_s1 && !load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!smp_stall) begin
			vld_s1 <= smp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!smp_stall && smp_valid) begin
			smp_s1 <= smp;
		end
	end

	// Magnitude of the sample; the most negative code maps to 32768.
	assign sample_u = smp_s1.sample;
	assign mag      = smp_s1.sample[ppm_ebp_pkg::SMP_W-1] ? (~sample_u + 16'd1) : sample_u;

	assign idx      = smp_s1.channel[ppm_ebp_pkg::CH_IDX_W-1:0];
	assign in_range = (int'(smp_s1.channel) < ppm_ebp_pkg::CHANNELS);
	assign env_cur  = env_q[idx];

	ppm_ebp_upd u_upd (
		.env           (env_cur),
		.mag           (mag),
		.alpha_attack  (alpha_attack_q),
		.alpha_release (alpha_release_q),
		.env_next      (env_next)
	);

	// A block start drops the old peak, so the peak restarts at this envelope.
	assign peak_base = smp_s1.block_start ? '0 : peak_q[idx];
	assign peak_next = (env_next > peak_base) ? env_next : peak_base;

	// State is written as the item moves into the result register, so the
	// next item in stage 1 already sees it, even on the same channel.
	assign commit = vld_s1 && load_s2 && in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppm_ebp_pkg::CHANNELS; i++) begin
				env_q[i]  <= '0;
				peak_q[i] <= '0;
			end
		end else if (commit) begin
			env_q[idx]  <= env_next;
			peak_q[idx] <= peak_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (load_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && vld_s1) begin
			res_s2.out_channel <= smp_s1.channel;
			res_s2.envelope    <= in_range ? env_next[ppm_ebp_pkg::ENV_W-1:8] : '0;
			res_s2.block_peak  <= in_range ? peak_next[ppm_ebp_pkg::ENV_W-1:8] : '0;
		end
	end

	assign res_valid = vld_s2;
	assign res       = res_s2;

endmodule

`default_nettype wire

>>> hdl/ppm_ebp_chk.sv
// Port-level checker for the peak program meter, bound to the top level.
// Depends on ppm_ebp_pkg for the item structs.
`timescale 1ns / 1ps
`default_nettype none

module ppm_ebp_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              smp_valid,
	input wire logic              smp_stall,
	input wire logic              res_valid,
	input wire logic              res_stall,
	input wire ppm_ebp_pkg::res_t res
);

	// A held result does not change.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// Samples are held back only when a result is waiting on the far side.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		smp_stall |-> res_valid && res_stall)
		else $error("sample stall without result backpressure");

	// An item taken, with no result stall while it sits in stage 1, comes out valid.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_valid && !smp_stall) ##1 !res_stall |=> res_valid)
		else $error("result missing after accepted item");

	// The envelope stays within range and never exceeds the block peak.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.envelope <= 16'h8000) && (res.block_peak >= res.envelope))
		else $error("envelope out of range or above block peak");

endmodule

bind ppm_envelope_block_peak_core ppm_ebp_chk u_chk (.*);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the per-channel peak program meter core.
// Depends on ppm_ebp_pkg and ppm_envelope_block_peak_core; needs no other files.
`timescale 1ns / 1ps

module tb_top;
	import ppm_ebp_pkg::*;

	// Register byte addresses: one 32-bit word per coefficient.
	localparam logic [2:0] ADDR_ATTACK  = {REG_ALPHA_ATTACK, 2'b00};
	localparam logic [2:0] ADDR_RELEASE = {REG_ALPHA_RELEASE, 2'b00};
	localparam logic [ALPHA_W-1:0] ALPHA_MAX = {ALPHA_W{1'b1}};

	// Settle time after the last reading, with slack beyond the core's pipeline.
	localparam int SETTLE_CYCLES = 6;
	// Watchdog limit; it must exceed the slowest correct run of roughly 1850 items plus holds.
	localparam int CYCLE_LIMIT = 400000;
	// The receiver stops taking results for a long stretch at these counts.
	localparam int HOLD_AT_A = 700;
	localparam int HOLD_AT_B = 1400;
	localparam int HOLD_LEN  = 80;

	typedef struct {
		smp_t item;
		bit   drain_first;
	} queued_sample_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        smp_valid = 1'b0;
	logic        smp_stall;
	smp_t        smp = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Items waiting to be offered, and the meter readings they must produce.
	queued_sample_t sample_q[$];
	res_t           expected_levels[$];

	// The testbench's own copy of the meter state and coefficients.
	logic [ENV_W-1:0]   env_reg[CHANNELS];
	logic [ENV_W-1:0]   peak_reg[CHANNELS];
	logic [ALPHA_W-1:0] attack_coef;
	logic [ALPHA_W-1:0] release_coef;

	// Idling is switched per phase so that some stretches run back to back.
	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;

	int unsigned err_cnt = 0;
	int unsigned result_cnt = 0;
	int unsigned cycle_cnt = 0;

	ppm_envelope_block_peak_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp       (smp),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Meter update for one sample. The magnitude of -32768 is 32768, so it
	// needs 17 bits. When the stored envelope is strictly above the scaled
	// magnitude the channel decays; otherwise it attacks. Both attack
	// products are summed at full width and truncated once, as the core does.
	function automatic res_t meter_step(input smp_t s);
		logic [16:0] mag;
		logic [63:0] env_prev;
		logic [63:0] mag_scaled;
		logic [63:0] env_next;
		logic [63:0] unity;
		int unsigned ch;
		res_t r;
		mag = s.sample[SMP_W-1] ? 17'(17'h10000 - {1'b0, s.sample}) : {1'b0, s.sample};
		ch = s.channel;
		r.out_channel = s.channel;
		if (ch >= CHANNELS) begin
			// A channel without storage leaves the state alone and reads zero.
			r.envelope = '0;
			r.block_peak = '0;
			return r;
		end
		unity = 64'd1 << ALPHA_W;
		env_prev = 64'(env_reg[ch]);
		mag_scaled = 64'(mag) << 8;
		if (env_prev > mag_scaled) begin
			env_next = (env_prev * (unity - 64'(release_coef))) >> ALPHA_W;
		end else begin
			env_next = (64'(attack_coef) * mag_scaled
				+ (unity - 64'(attack_coef)) * env_prev) >> ALPHA_W;
		end
		env_reg[ch] = env_next[ENV_W-1:0];
		// A block start clears the peak first, so the peak then equals the
		// new envelope.
		if (s.block_start) begin
			peak_reg[ch] = '0;
		end
		if (env_reg[ch] > peak_reg[ch]) begin
			peak_reg[ch] = env_reg[ch];
		end
		r.envelope = env_reg[ch][ENV_W-1:8];
		r.block_peak = peak_reg[ch][ENV_W-1:8];
		return r;
	endfunction

	function automatic int unsigned draw_gap(input bit idle_on);
		if (!idle_on || $urandom_range(0, 1) == 0) begin
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction

	function automatic void add_sample(input logic [SMP_W-1:0] value, input int unsigned ch,
			input bit start, input bit drain);
		queued_sample_t q;
		q.item.sample = value;
		q.item.channel = CH_W'(ch);
		q.item.block_start = start;
		q.drain_first = drain;
		sample_q.push_back(q);
	endfunction

	// Sample values mix full-range noise, quiet signal, full-scale peaks,
	// the exact extremes and silence, so both attack and decay get exercised.
	function automatic logic [SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 6))
			0, 1: begin
				return SMP_W'($urandom);
			end
			2: begin
				return SMP_W'(int'($urandom_range(0, 511)) - 256);
			end
			3: begin
				if ($urandom_range(0, 1) == 1) begin
					return SMP_W'(32767 - int'($urandom_range(0, 2047)));
				end
				return SMP_W'(-32768 + int'($urandom_range(0, 2047)));
			end
			4: begin
				case ($urandom_range(0, 3))
					0: return 16'h7FFF;
					1: return 16'h8000;
					2: return 16'hFFFF;
					default: return 16'h0001;
				endcase
			end
			default: begin
				return '0;
			end
		endcase
	endfunction

	function automatic void add_random(input int unsigned n, input bit with_drains);
		for (int unsigned i = 0; i < n; i++) begin
			add_sample(rand_sample(), $urandom_range(0, CHANNELS - 1),
				$urandom_range(0, 9) == 0, with_drains && $urandom_range(0, 39) == 0);
		end
	endfunction

	// Sample driver. An item is taken at an edge where valid is high and
	// stall is low; only then is it run through the predictor. After each
	// item the driver may idle for a drawn number of cycles. An item marked
	// drain_first is held back until every earlier reading has come out.
	int unsigned src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid <= 1'b0;
			smp <= '0;
			src_gap <= 0;
		end else begin
			if (smp_valid && !smp_stall) begin
				expected_levels.push_back(meter_step(smp));
			end
			if (smp_valid && smp_stall) begin
				// Hold the stalled item unchanged.
			end else if (src_gap != 0) begin
				smp_valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (sample_q.size() != 0
					&& !(sample_q[0].drain_first && expected_levels.size() != 0)) begin
				smp <= sample_q[0].item;
				smp_valid <= 1'b1;
				src_gap <= draw_gap(src_idle);
				void'(sample_q.pop_front());
			end else begin
				smp_valid <= 1'b0;
			end
		end
	end

	// Result monitor and receiver. Every accepted reading is checked against
	// the oldest expectation. After each reading the receiver stalls for a
	// drawn number of cycles; at two fixed counts it holds off much longer
	// so that the pipeline fills and the core stalls its sample input.
	int unsigned snk_wait = 0;
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
			snk_wait = 0;
		end else begin
			if (res_valid && !res_stall) begin
				result_cnt++;
				if (expected_levels.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected reading %p", $time, res);
				end else begin
					want = expected_levels.pop_front();
					if (res.out_channel !== want.out_channel) begin
						err_cnt++;
						$display("%0t: out_channel expected %0d got %0d", $time,
							want.out_channel, res.out_channel);
					end
					if (res.envelope !== want.envelope) begin
						err_cnt++;
						$display("%0t: envelope ch%0d expected %0d got %0d", $time,
							want.out_channel, want.envelope, res.envelope);
					end
					if (res.block_peak !== want.block_peak) begin
						err_cnt++;
						$display("%0t: block_peak ch%0d expected %0d got %0d", $time,
							want.out_channel, want.block_peak, res.block_peak);
					end
				end
				if (result_cnt == HOLD_AT_A || result_cnt == HOLD_AT_B) begin
					snk_wait = HOLD_LEN;
				end else begin
					snk_wait = draw_gap(snk_idle);
				end
			end else if (snk_wait != 0) begin
				snk_wait = snk_wait - 1;
			end
			res_stall <= (snk_wait != 0);
		end
	end

	// Register write: a setup phase, then an access phase that completes at
	// the edge where pready is seen high. The shadow coefficient follows
	// with only the low 24 bits of the data kept.
	task automatic cfg_write(input logic [2:0] addr, input logic [ALPHA_W-1:0] value);
		logic [31:0] data;
		data = {8'($urandom), value};
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr[2])
			REG_ALPHA_ATTACK: attack_coef = data[ALPHA_W-1:0];
			REG_ALPHA_RELEASE: release_coef = data[ALPHA_W-1:0];
		endcase
	endtask

	task automatic set_coefs(input logic [ALPHA_W-1:0] attack, input logic [ALPHA_W-1:0] decay);
		cfg_write(ADDR_ATTACK, attack);
		cfg_write(ADDR_RELEASE, decay);
	endtask

	// Returns once every queued item is taken, every reading has come out
	// and the pipeline has had time to go quiet.
	task automatic wait_idle();
		while (sample_q.size() != 0 || smp_valid || expected_levels.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		for (int i = 0; i < CHANNELS; i++) begin
			env_reg[i] = '0;
			peak_reg[i] = '0;
		end
		attack_coef = ALPHA_ATTACK_RST;
		release_coef = ALPHA_RELEASE_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset coefficients: full-scale positive and negative,
		// silence after signal (decay), the smallest magnitudes, a fresh
		// channel fed zero (envelope equal to the magnitude, so attack),
		// and block starts on every channel.
		src_idle = 1'b0;
		snk_idle = 1'b0;
		add_sample(16'h7FFF, 0, 1'b1, 1'b0);
		add_sample(16'h8000, 0, 1'b0, 1'b0);
		add_sample(16'h0000, 0, 1'b0, 1'b0);
		add_sample(16'hFFFF, 0, 1'b0, 1'b0);
		add_sample(16'h0001, 0, 1'b1, 1'b0);
		add_sample(16'h8000, 1, 1'b1, 1'b0);
		add_sample(16'h5555, 2, 1'b1, 1'b0);
		add_sample(16'hAAAA, 3, 1'b1, 1'b0);
		add_sample(16'h7FFF, 4, 1'b1, 1'b0);
		add_sample(16'h8001, 5, 1'b1, 1'b0);
		add_sample(16'h0100, 6, 1'b1, 1'b0);
		add_sample(16'h0000, 7, 1'b1, 1'b0);
		add_sample(16'h0000, 1, 1'b1, 1'b0);
		wait_idle();

		// Directed, both coefficients at their maximum: the envelope jumps
		// almost to the magnitude and collapses to zero on silence, and a
		// block start after the collapse leaves a small peak.
		set_coefs(ALPHA_MAX, ALPHA_MAX);
		add_sample(16'h8000, 0, 1'b1, 1'b0);
		add_sample(16'h8000, 0, 1'b0, 1'b0);
		add_sample(16'h0000, 0, 1'b0, 1'b0);
		add_sample(16'h0000, 0, 1'b1, 1'b0);
		add_sample(16'h7FFF, 5, 1'b0, 1'b0);
		add_sample(16'h0040, 5, 1'b0, 1'b0);
		add_sample(16'h0040, 5, 1'b1, 1'b0);
		add_sample(16'h7FFF, 7, 1'b0, 1'b0);
		add_sample(16'hC000, 7, 1'b1, 1'b0);
		add_sample(16'h8000, 2, 1'b0, 1'b0);
		wait_idle();

		// Both coefficients at zero: the envelopes freeze.
		src_idle = 1'b1;
		snk_idle = 1'b1;
		set_coefs('0, '0);
		add_random(100, 1'b0);
		wait_idle();

		// Back to the reset coefficients with idling on both sides.
		set_coefs(ALPHA_ATTACK_RST, ALPHA_RELEASE_RST);
		add_random(500, 1'b0);
		wait_idle();

		// Random coefficients, items back to back; the first long receiver
		// hold lands here.
		src_idle = 1'b0;
		snk_idle = 1'b0;
		set_coefs(ALPHA_W'($urandom), ALPHA_W'($urandom));
		add_random(400, 1'b0);
		wait_idle();

		// Fast attack, random decay; the sender now and then waits for
		// every reading to come out before it goes on.
		src_idle = 1'b1;
		snk_idle = 1'b1;
		set_coefs(ALPHA_W'($urandom_range(24'h800000, ALPHA_MAX)), ALPHA_W'($urandom));
		add_random(400, 1'b1);
		wait_idle();

		// Random coefficients, idling only on the receiving side.
		src_idle = 1'b0;
		set_coefs(ALPHA_W'($urandom), ALPHA_W'($urandom_range(0, 24'h00FFFF)));
		add_random(400, 1'b0);
		wait_idle();

		if (err_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/ppm_ebp_pkg.sv
hdl/ppm_ebp_upd.sv
hdl/ppm_envelope_block_peak_core.sv
hdl/ppm_ebp_chk.sv
tb/tb_top.sv
